>>> hw/rtl/ise_pkg.sv
// ----------------------------------------------------------------------------
// ise_pkg
// Shared types, constants and the ordering function for the sort engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ise_pkg;

    // Element width and default capacity of the cell chain.
    localparam int DATA_W    = 32;
    localparam int DEPTH_DEF = 64;

    // Configuration port address width and register indexes.
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam logic [PADDR_W-1:0] ADDR_DESCENDING = 3'd0;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic load;   // write the incoming element into the selected cell
        logic shift;  // move every element one cell toward cell zero
        logic sort;   // perform one compare-exchange phase
        logic phase;  // parity of the cell that leads each compared pair
        logic desc;   // order in force for this list
    } t_cell_ctrl;

    // True when element a must be placed after element b.
    function automatic logic goes_after(input logic signed [DATA_W-1:0] a,
                                        input logic signed [DATA_W-1:0] b,
                                        input logic desc);
        goes_after = desc ? (a < b) : (a > b);
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ise_if.sv
// ----------------------------------------------------------------------------
// ise_if
// Ready/valid channels for list elements going in and sorted results coming out.
// ----------------------------------------------------------------------------
`default_nettype none

// Input channel: one list element per request.
interface ise_in_if import ise_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value;
    logic                     last_item;

    modport source (output valid, output value, output last_item, input ready);
    modport sink   (input valid, input value, input last_item, output ready);
endinterface

// Output channel: one sorted element per request.
interface ise_out_if import ise_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_out;
    logic                     overflow;

    modport source (output valid, output sorted_value, output last_out,
                    output overflow, input ready);
    modport sink   (input valid, input sorted_value, input last_out,
                    input overflow, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/ise_cell.sv
// ----------------------------------------------------------------------------
// ise_cell
// One storage cell of the sort chain: load, shift toward cell zero, or
// compare-exchange with the neighbor that forms its pair in this phase.
// ----------------------------------------------------------------------------
`default_nettype none

module ise_cell import ise_pkg::*; #(
    parameter int INDEX = 0
) (
    input  wire logic                     i_clk,
    input  wire t_cell_ctrl               i_ctrl,
    input  wire logic                     i_load_sel,
    input  wire logic signed [DATA_W-1:0] i_load_val,
    input  wire logic signed [DATA_W-1:0] i_left_val,
    input  wire logic signed [DATA_W-1:0] i_right_val,
    input  wire logic                     i_self_vld,
    input  wire logic                     i_right_vld,
    output logic signed [DATA_W-1:0]      o_val
);

    localparam logic IDX_PARITY = INDEX[0];
    localparam logic HAS_LEFT   = (INDEX > 0);

    logic signed [DATA_W-1:0] r_val;
    logic signed [DATA_W-1:0] n_val;
    logic                     w_lead;

    // This cell leads its pair when its parity matches the phase.
    assign w_lead = (IDX_PARITY == i_ctrl.phase);

    // Next value: load, shift, or exchange with the pair partner.
    always_comb begin
        n_val = r_val;
        if (i_ctrl.load && i_load_sel) begin
            n_val = i_load_val;
        end else if (i_ctrl.shift) begin
            n_val = i_right_val;
        end else if (i_ctrl.sort) begin
            if (w_lead) begin
                if (i_right_vld && goes_after(r_val, i_right_val, i_ctrl.desc)) begin
                    n_val = i_right_val;
                end
            end else if (HAS_LEFT && i_self_vld) begin
                if (goes_after(i_left_val, r_val, i_ctrl.desc)) begin
                    n_val = i_left_val;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule

`default_nettype wire

>>> hw/rtl/insertion_sort_engine_core.sv
// Sorting: the chain runs the N odd-even exchange phases of an N-element list
// after its last element is accepted, and then offers the first result.
// Throughput: one element per cycle while loading, one result per cycle while
// emitting and the output is ready; one list occupies the chain at a time.
// Reset (synchronous, active low) clears the count, overflow flag, direction and
// sequencer; cell contents are not reset and are only read below the count.
// ----------------------------------------------------------------------------
// insertion_sort_engine_core
// Collects a list of signed elements into a chain of cells, orders it by
// neighbor compare-exchange phases, and streams the ordered list out.
// ----------------------------------------------------------------------------
`default_nettype none

module insertion_sort_engine_core import ise_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    ise_in_if.sink                   i_in,
    ise_out_if.source                o_out,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    typedef enum logic [2:0] {
        S_LOAD = 3'b001,
        S_SORT = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_pass,  n_pass;
    logic              r_dropped, n_dropped;
    logic              r_desc;
    logic              r_sort_desc, n_sort_desc;

    logic              w_in_acc;
    logic              w_out_acc;
    logic              w_full;
    logic              w_cfg_wr;
    logic              w_sel_desc;
    t_cell_ctrl        w_ctrl;

    logic signed [DATA_W-1:0] w_val [DEPTH];
    logic [DEPTH-1:0]         w_vld;
    logic [DEPTH-1:0]         w_sel;

    // Configuration port: direction register, zero-wait writes and reads.
    // Registers are decoded by word; the byte offset bits are ignored.
    assign pready     = 1'b1;
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign w_sel_desc = (paddr[PADDR_W-1:2] == ADDR_DESCENDING[PADDR_W-1:2]);
    assign prdata     = w_sel_desc ? {{(PDATA_W-1){1'b0}}, r_desc} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desc <= 1'b0;
        end else if (w_cfg_wr && w_sel_desc) begin
            r_desc <= pwdata[0];
        end
    end

    // Handshakes.
    assign i_in.ready = (r_state == S_LOAD);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_acc  = o_out.valid && o_out.ready;
    assign w_full     = (r_count == CNT_FULL);

    // Sequencer: load, run exchange phases, then stream out.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pass      = r_pass;
        n_dropped   = r_dropped;
        n_sort_desc = r_sort_desc;
        case (r_state)
            S_LOAD: begin
                if (w_in_acc) begin
                    if (w_full) begin
                        n_dropped = 1'b1;
                    end else begin
                        n_count = r_count + CNT_ONE;
                    end
                    if (i_in.last_item) begin
                        n_state     = S_SORT;
                        n_pass      = '0;
                        n_sort_desc = r_desc;
                    end
                end
            end
            S_SORT: begin
                n_pass = r_pass + CNT_ONE;
                if (r_pass == CNT_W'(r_count - CNT_ONE)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_acc) begin
                    n_count = r_count - CNT_ONE;
                    if (r_count == CNT_ONE) begin
                        n_state   = S_LOAD;
                        n_dropped = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_pass      <= '0;
            r_dropped   <= 1'b0;
            r_sort_desc <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pass      <= n_pass;
            r_dropped   <= n_dropped;
            r_sort_desc <= n_sort_desc;
        end
    end

    // Control broadcast to the chain.
    always_comb begin
        w_ctrl.load  = w_in_acc && !w_full;
        w_ctrl.shift = (r_state == S_EMIT) && w_out_acc;
        w_ctrl.sort  = (r_state == S_SORT);
        w_ctrl.phase = r_pass[0];
        w_ctrl.desc  = r_sort_desc;
    end

    // The chain of cells; cells below the count hold the list.
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic signed [DATA_W-1:0] w_left;
        logic signed [DATA_W-1:0] w_right;
        logic                     w_right_vld;

        assign w_sel[gi] = (r_count == CNT_W'(gi));
        assign w_vld[gi] = (CNT_W'(gi) < r_count);

        if (gi == 0) begin : g_first
            assign w_left = w_val[gi];
        end else begin : g_inner_l
            assign w_left = w_val[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_end
            assign w_right     = w_val[gi];
            assign w_right_vld = 1'b0;
        end else begin : g_inner_r
            assign w_right     = w_val[gi+1];
            assign w_right_vld = w_vld[gi+1];
        end

        ise_cell #(
            .INDEX (gi)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_load_sel  (w_sel[gi]),
            .i_load_val  (i_in.value),
            .i_left_val  (w_left),
            .i_right_val (w_right),
            .i_self_vld  (w_vld[gi]),
            .i_right_vld (w_right_vld),
            .o_val       (w_val[gi])
        );
    end

    // Results stream from cell zero.
    assign o_out.valid        = (r_state == S_EMIT);
    assign o_out.sorted_value = w_val[0];
    assign o_out.last_out     = (r_count == CNT_ONE);
    assign o_out.overflow     = r_dropped;

    // The input and output sides are never open in the same cycle.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input ready while results pending");

    // The count never exceeds the chain length.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("element count beyond capacity");

    // A result is only offered while elements remain.
    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (r_count != '0))
        else $error("result offered with empty chain");

    // After the final result is taken the chain is empty and loading resumes.
    a_list_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_out.last_out) |=> ((r_count == '0) && (r_state == S_LOAD)
                                           && !r_dropped))
        else $error("list did not close after final result");

    // The two head cells are in order throughout emission.
    if (DEPTH > 1) begin : g_order_chk
        a_head_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (o_out.valid && (r_count > CNT_ONE))
                |-> !goes_after(w_val[0], w_val[1], r_sort_desc))
            else $error("emitted elements out of order");
    end

endmodule

`default_nettype wire

>>> dv/insertion_sort_engine_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// insertion_sort_engine_checker
// Watches the element and result channels and the register port of the sort
// engine. It collects each list, orders it in the direction in force when the
// last element arrives, and compares every result against that order.
// ----------------------------------------------------------------------------

module insertion_sort_engine_checker import ise_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    ise_in_if                        i_in_mon,
    ise_out_if                       i_out_mon,
    input  wire logic                i_psel,
    input  wire logic                i_penable,
    input  wire logic                i_pwrite,
    input  wire logic [PADDR_W-1:0]  i_paddr,
    input  wire logic [PDATA_W-1:0]  i_pwdata,
    input  wire logic                i_pready,
    output int unsigned              o_fail_count,
    output int unsigned              o_outstanding,
    output int unsigned              o_results_seen
);

    // One sorted element as it should appear on the result channel.
    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic                     ovf;
    } t_sorted_rec;

    t_sorted_rec              sorted_due[$];
    logic signed [DATA_W-1:0] list_store[$];
    logic                     list_dropped = 1'b0;
    logic                     desc_mode    = 1'b0;
    int unsigned              fail_count   = 0;
    int unsigned              results_seen = 0;

    // Straight insertion sort of the collected list; equal values keep
    // their arrival order.
    function automatic void order_list();
        logic signed [DATA_W-1:0] key;
        int                       pos;
        for (int i = 1; i < list_store.size(); i++) begin
            key = list_store[i];
            pos = i;
            while (pos > 0 && (desc_mode ? (list_store[pos-1] < key)
                                         : (list_store[pos-1] > key))) begin
                list_store[pos] = list_store[pos-1];
                pos--;
            end
            list_store[pos] = key;
        end
    endfunction

    function automatic void compare_field(input string name,
                                          input logic signed [DATA_W-1:0] want,
                                          input logic signed [DATA_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Register writes, element requests and result requests, in edge order.
    always @(posedge i_clk) begin
        t_sorted_rec rec;
        if (!i_rst_n) begin
            sorted_due.delete();
            list_store.delete();
            list_dropped = 1'b0;
            desc_mode    = 1'b0;
        end else begin
            // Only the direction register exists; other addresses are ignored.
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr == ADDR_DESCENDING) begin
                desc_mode = i_pwdata[0];
            end

            // Collect an element; a full store drops it and marks the list.
            if (i_in_mon.valid && i_in_mon.ready) begin
                if (list_store.size() < DEPTH) begin
                    list_store.insert(list_store.size(), i_in_mon.value);
                end else begin
                    list_dropped = 1'b1;
                end
                if (i_in_mon.last_item) begin
                    order_list();
                    foreach (list_store[k]) begin
                        rec.value = list_store[k];
                        rec.last  = (k == list_store.size() - 1);
                        rec.ovf   = list_dropped;
                        sorted_due.insert(sorted_due.size(), rec);
                    end
                    list_store.delete();
                    list_dropped = 1'b0;
                end
            end

            // Compare a result against the oldest expected element.
            if (i_out_mon.valid && i_out_mon.ready) begin
                results_seen++;
                if (sorted_due.size() == 0) begin
                    $display("%0t: unexpected result %0d (last %0b, overflow %0b)", $time,
                             i_out_mon.sorted_value, i_out_mon.last_out,
                             i_out_mon.overflow);
                    fail_count++;
                end else begin
                    rec = sorted_due.pop_front();
                    compare_field("sorted_value", rec.value, i_out_mon.sorted_value);
                    compare_field("last_out", rec.last, i_out_mon.last_out);
                    compare_field("overflow", rec.ovf, i_out_mon.overflow);
                end
            end
        end
        o_fail_count   <= fail_count;
        o_outstanding  <= sorted_due.size();
        o_results_seen <= results_seen;
    end

endmodule

>>> dv/insertion_sort_engine_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// insertion_sort_engine_core_tb
// Drives lists of signed elements into the sort engine with random gaps and
// result back-pressure, changes the sort direction between lists, and lets
// the checker compare every sorted result. Covers single-element lists,
// extreme values, duplicates, full and overflowing stores, and a direction
// change in the middle of a list.
// ----------------------------------------------------------------------------

module insertion_sort_engine_core_tb;
    import ise_pkg::*;

    localparam int                  DEPTH         = DEPTH_DEF;
    localparam int                  RANDOM_ITEMS  = 200;
    localparam int                  SETTLE_CYCLES = 8;
    localparam int                  HOLD_CYCLES   = 300;
    localparam int                  CYCLE_LIMIT   = 200_000;
    localparam logic [PADDR_W-1:0]  ADDR_SPARE    = 3'd4;
    localparam logic signed [DATA_W-1:0] VAL_MIN  = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX  = 32'sh7FFF_FFFF;

    // How the elements of a random list are drawn.
    typedef enum logic [1:0] {
        FILL_WIDE,
        FILL_NARROW,
        FILL_EDGE
    } t_fill;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                no_idle;
    logic                hold_req;
    int unsigned         fail_count;
    int unsigned         outstanding;
    int unsigned         results_seen;
    int unsigned         cycle_count = 0;
    int unsigned         items_sent;
    int unsigned         lists_sent;
    int unsigned         overflow_lists;

    ise_in_if  in_ch();
    ise_out_if out_ch();

    insertion_sort_engine_core #(.DEPTH(DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    insertion_sort_engine_checker #(.DEPTH(DEPTH)) checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_mon       (in_ch),
        .i_out_mon      (out_ch),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_pready       (pready),
        .o_fail_count   (fail_count),
        .o_outstanding  (outstanding),
        .o_results_seen (results_seen)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still expected",
                     cycle_count, outstanding);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off, and a stretch without stalls.
    initial begin
        logic hold_done;
        hold_done = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else if (no_idle) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= 29);
            end
        end
    end

    function automatic logic signed [DATA_W-1:0] pick_value(input t_fill fill);
        logic signed [DATA_W-1:0] v;
        v = $urandom();
        case (fill)
            FILL_NARROW: begin
                v = $urandom_range(8);
                v = v - 4;
            end
            FILL_EDGE: begin
                case ($urandom_range(5))
                    0: v = VAL_MIN;
                    1: v = VAL_MAX;
                    2: v = 0;
                    3: v = -1;
                    4: v = VAL_MIN + 1;
                    default: v = VAL_MAX - 1;
                endcase
            end
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // Offer one element after a random gap and wait for its request to complete.
    task automatic send_item(input logic signed [DATA_W-1:0] v, input logic last);
        while (!no_idle && $urandom_range(99) < 29) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.value     <= v;
        in_ch.last_item <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_list(input int len, input t_fill fill);
        for (int k = 0; k < len; k++) begin
            send_item(pick_value(fill), k == len - 1);
        end
        lists_sent++;
        if (len > DEPTH) overflow_lists++;
    endtask

    // Stop offering, wait for every expected result, then let the engine settle.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write: setup cycle, then access cycle.
    task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Stimulus and verdict.
    initial begin
        int    len;
        int    list_no;
        int    r;
        int    random_start;
        t_fill fill;

        items_sent     = 0;
        lists_sent     = 0;
        overflow_lists = 0;
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.value     <= '0;
        in_ch.last_item <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        no_idle         <= 1'b0;
        hold_req        <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A single-element list in the reset (ascending) order.
        send_item(0, 1'b1);
        lists_sent++;

        // Extremes and duplicates, ascending.
        send_item(VAL_MAX, 1'b0);
        send_item(VAL_MIN, 1'b0);
        send_item(-1, 1'b0);
        send_item(0, 1'b0);
        send_item(1, 1'b0);
        send_item(VAL_MIN, 1'b0);
        send_item(VAL_MAX, 1'b0);
        send_item(5, 1'b1);
        lists_sent++;
        wait_drained();

        // Descending; only bit 0 of the written word counts.
        reg_write(ADDR_DESCENDING, 32'hFFFF_FFFF);
        send_item(7, 1'b0);
        send_item(7, 1'b0);
        send_item(-7, 1'b0);
        send_item(VAL_MIN, 1'b0);
        send_item(VAL_MAX, 1'b1);
        lists_sent++;
        wait_drained();

        // A write to an unused address must leave the direction alone.
        reg_write(ADDR_SPARE, 32'h0000_0000);
        send_item(3, 1'b0);
        send_item(-3, 1'b1);
        lists_sent++;
        wait_drained();

        // Direction changed partway through a list; the last element decides.
        send_item(10, 1'b0);
        send_item(-20, 1'b0);
        send_item(30, 1'b0);
        wait_drained();
        reg_write(ADDR_DESCENDING, 32'h0000_0002);
        send_item(-40, 1'b1);
        lists_sent++;

        // Random lists: mostly short, a full store and an overflowing one.
        hold_req     <= 1'b1;
        list_no      = 0;
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            if (list_no == 2) begin
                len = DEPTH;
            end else if (list_no == 9) begin
                len = DEPTH + 2;
            end else begin
                r = $urandom_range(99);
                if (r < 75)      len = $urandom_range(8, 1);
                else if (r < 97) len = $urandom_range(20, 9);
                else             len = $urandom_range(DEPTH - 1, 30);
            end
            fill = t_fill'($urandom_range(2));
            no_idle <= (list_no >= 2 && list_no < 6);
            if (list_no % 6 == 5) begin
                wait_drained();
                reg_write(($urandom_range(3) == 0) ? ADDR_SPARE : ADDR_DESCENDING,
                          $urandom());
            end
            send_list(len, fill);
            list_no++;
        end

        // Drain and report.
        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("Ran %0d lists of %0d elements (%0d overflowing) in both orders.",
                 lists_sent, items_sent, overflow_lists);
        $display("Checked %0d sorted results.", results_seen);
        if (fail_count == 0 && outstanding == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
